// ===== hdl/lavm_pkg.sv =====
`default_nettype none
package lavm_pkg;

  localparam int WordBits   = 32;
  localparam int FracBits   = 16;
  localparam int QueueDepth = 2;
  // floor(0.0001 * 2^FracBits)
  localparam logic [WordBits-1:0] NormMinLen = WordBits'((64'd1 << FracBits) / 10000);

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t upref_x;
    word_t upref_y;
    word_t upref_z;
  } lavm_in_t;

  typedef struct packed {
    word_t side_x;
    word_t side_y;
    word_t side_z;
    word_t cam_up_x;
    word_t cam_up_y;
    word_t cam_up_z;
    word_t back_x;
    word_t back_y;
    word_t back_z;
    word_t move_x;
    word_t move_y;
    word_t move_z;
  } lavm_out_t;

  // job handed from front to back: eye, reference up, raw forward
  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t up_x;
    word_t up_y;
    word_t up_z;
    word_t fwd_x;
    word_t fwd_y;
    word_t fwd_z;
  } lavm_job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } lavm_qstat_t;

endpackage
`default_nettype wire

// ===== hdl/lavm_front.sv =====
`default_nettype none
module lavm_front
  import lavm_pkg::*;
(
  input  wire logic      start,
  output logic           busy,
  input  wire lavm_in_t  item_i,
  input  wire logic      full_i,
  output logic           push_o,
  output lavm_job_t      job_o
);

  function automatic word_t sat_diff(input word_t a, input word_t b);
    logic signed [WordBits:0] d;
    d = (WordBits+1)'(a) - (WordBits+1)'(b);
    if (d[WordBits] != d[WordBits-1]) begin
      return d[WordBits] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    end
    return d[WordBits-1:0];
  endfunction

  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    job_o.eye_x = item_i.eye_x;
    job_o.eye_y = item_i.eye_y;
    job_o.eye_z = item_i.eye_z;
    job_o.up_x  = item_i.upref_x;
    job_o.up_y  = item_i.upref_y;
    job_o.up_z  = item_i.upref_z;
    job_o.fwd_x = sat_diff(item_i.target_x, item_i.eye_x);
    job_o.fwd_y = sat_diff(item_i.target_y, item_i.eye_y);
    job_o.fwd_z = sat_diff(item_i.target_z, item_i.eye_z);
  end

endmodule
`default_nettype wire

// ===== hdl/lavm_queue.sv =====
`default_nettype none
module lavm_queue
  import lavm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire lavm_job_t data_i,
  input  wire logic      pop_i,
  output lavm_qstat_t    stat_o,
  output lavm_job_t      data_o
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);

  lavm_job_t mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntBits'(QueueDepth));
  assign stat_o.valid = (cnt_q != '0);
  assign data_o       = mem_q[rd_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lavm_back.sv =====
`default_nettype none
module lavm_back
  import lavm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lavm_qstat_t qstat_i,
  input  wire lavm_job_t   job_i,
  output logic             pop_o,
  output logic             done_o,
  output lavm_out_t        result_o
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_SQRT, S_DIV} state_e;
  typedef enum logic [2:0] {K_SQ0, K_SQ, K_SH0, K_ADD, K_SUB} kind_e;
  typedef enum logic [2:0] {E_NONE, E_NORM, E_S, E_U, E_MV} act_e;

  localparam int AccBits = 2 * WordBits + 2;
  localparam int DvdBits = WordBits + FracBits;
  localparam logic [4:0] LastPc = 5'd26;

  state_e state_q;
  logic [4:0] pc_q;
  logic nsel_q;                       // 0: normalizing forward, 1: side
  word_t ex_q, ey_q, ez_q, upx_q, upy_q, upz_q;
  word_t fx_q, fy_q, fz_q, sx_q, sy_q, sz_q, ux_q, uy_q, uz_q;
  word_t mvx_q, mvy_q;
  logic signed [2*WordBits-1:0] p_q;
  logic signed [AccBits-1:0]    acc_q, acc_d;
  // root unit
  logic [2*WordBits-1:0] sq_n_q;
  logic [WordBits+1:0]   sq_rem_q, sq_rem_d;
  logic [WordBits-1:0]   sq_root_q, sq_root_d, len_q;
  logic [WordBits+3:0]   sq_sh, sq_trial;
  logic [4:0]            sq_cnt_q;
  // divide lanes, shared divisor
  logic [DvdBits-1:0]  dq_q [3];
  logic [DvdBits-1:0]  dq_d [3];
  logic [WordBits-1:0] dr_q [3];
  logic [WordBits-1:0] dr_d [3];
  logic [WordBits:0]   dtry [3];
  logic                dneg_q [3];
  word_t               dres [3];
  word_t               nv [3];
  logic [5:0]          dcnt_q;

  word_t op_a, op_b, acc_sat, mv_val;
  kind_e kind;
  act_e  act;
  logic [1:0] dst;
  logic  neg;
  logic signed [2*WordBits-FracBits-1:0] p_sh;
  lavm_out_t res_q;
  logic done_q;

  function automatic word_t sat_acc(input logic signed [AccBits-1:0] v);
    if (v > AccBits'($signed({1'b0, {(WordBits-1){1'b1}}}))) begin
      return {1'b0, {(WordBits-1){1'b1}}};
    end
    if (v < -AccBits'($signed({1'b0, 1'b1, {(WordBits-1){1'b0}}}))) begin
      return {1'b1, {(WordBits-1){1'b0}}};
    end
    return v[WordBits-1:0];
  endfunction

  function automatic word_t sat_div(input logic n, input logic [DvdBits-1:0] q);
    if (!n) begin
      if (q > DvdBits'({1'b0, {(WordBits-1){1'b1}}})) begin
        return {1'b0, {(WordBits-1){1'b1}}};
      end
      return q[WordBits-1:0];
    end
    if (q > DvdBits'({1'b1, {(WordBits-1){1'b0}}})) begin
      return {1'b1, {(WordBits-1){1'b0}}};
    end
    return '0 - q[WordBits-1:0];
  endfunction

  function automatic word_t sat_neg(input word_t v);
    if (v == {1'b1, {(WordBits-1){1'b0}}}) begin
      return {1'b0, {(WordBits-1){1'b1}}};
    end
    return -v;
  endfunction

  // micro-program: one multiply per step
  always_comb begin
    op_a = fx_q; op_b = fx_q; kind = K_SQ0; act = E_NONE; dst = 2'd0; neg = 1'b0;
    unique case (pc_q)
      5'd0:  begin op_a = fx_q; op_b = fx_q; kind = K_SQ0; end
      5'd1:  begin op_a = fy_q; op_b = fy_q; kind = K_SQ; end
      5'd2:  begin op_a = fz_q; op_b = fz_q; kind = K_SQ; act = E_NORM; end
      5'd3:  begin op_a = fy_q; op_b = upz_q; kind = K_SH0; end
      5'd4:  begin op_a = fz_q; op_b = upy_q; kind = K_SUB; act = E_S; dst = 2'd0; end
      5'd5:  begin op_a = fz_q; op_b = upx_q; kind = K_SH0; end
      5'd6:  begin op_a = fx_q; op_b = upz_q; kind = K_SUB; act = E_S; dst = 2'd1; end
      5'd7:  begin op_a = fx_q; op_b = upy_q; kind = K_SH0; end
      5'd8:  begin op_a = fy_q; op_b = upx_q; kind = K_SUB; act = E_S; dst = 2'd2; end
      5'd9:  begin op_a = sx_q; op_b = sx_q; kind = K_SQ0; end
      5'd10: begin op_a = sy_q; op_b = sy_q; kind = K_SQ; end
      5'd11: begin op_a = sz_q; op_b = sz_q; kind = K_SQ; act = E_NORM; end
      5'd12: begin op_a = sy_q; op_b = fz_q; kind = K_SH0; end
      5'd13: begin op_a = sz_q; op_b = fy_q; kind = K_SUB; act = E_U; dst = 2'd0; end
      5'd14: begin op_a = sz_q; op_b = fx_q; kind = K_SH0; end
      5'd15: begin op_a = sx_q; op_b = fz_q; kind = K_SUB; act = E_U; dst = 2'd1; end
      5'd16: begin op_a = sx_q; op_b = fy_q; kind = K_SH0; end
      5'd17: begin op_a = sy_q; op_b = fx_q; kind = K_SUB; act = E_U; dst = 2'd2; end
      5'd18: begin op_a = sx_q; op_b = ex_q; kind = K_SH0; end
      5'd19: begin op_a = sy_q; op_b = ey_q; kind = K_ADD; end
      5'd20: begin op_a = sz_q; op_b = ez_q; kind = K_ADD; act = E_MV; dst = 2'd0; neg = 1'b1; end
      5'd21: begin op_a = ux_q; op_b = ex_q; kind = K_SH0; end
      5'd22: begin op_a = uy_q; op_b = ey_q; kind = K_ADD; end
      5'd23: begin op_a = uz_q; op_b = ez_q; kind = K_ADD; act = E_MV; dst = 2'd1; neg = 1'b1; end
      5'd24: begin op_a = fx_q; op_b = ex_q; kind = K_SH0; end
      5'd25: begin op_a = fy_q; op_b = ey_q; kind = K_ADD; end
      5'd26: begin op_a = fz_q; op_b = ez_q; kind = K_ADD; act = E_MV; dst = 2'd2; end
      default: begin op_a = fx_q; op_b = fx_q; end
    endcase
  end

  assign p_sh = (2*WordBits-FracBits)'(p_q >>> FracBits);

  always_comb begin
    case (kind)
      K_SQ0:   acc_d = AccBits'(p_q);
      K_SQ:    acc_d = acc_q + AccBits'(p_q);
      K_SH0:   acc_d = AccBits'(p_sh);
      K_ADD:   acc_d = acc_q + AccBits'(p_sh);
      K_SUB:   acc_d = acc_q - AccBits'(p_sh);
      default: acc_d = acc_q;
    endcase
    acc_sat = sat_acc(acc_d);
    mv_val  = sat_acc(neg ? -acc_d : acc_d);
  end

  // restoring square root, two radicand bits a step
  always_comb begin
    sq_sh    = {sq_rem_q, sq_n_q[2*WordBits-1 -: 2]};
    sq_trial = (WordBits+4)'({sq_root_q, 2'b01});
    if (sq_sh >= sq_trial) begin
      sq_rem_d  = (WordBits+2)'(sq_sh - sq_trial);
      sq_root_d = {sq_root_q[WordBits-2:0], 1'b1};
    end else begin
      sq_rem_d  = (WordBits+2)'(sq_sh);
      sq_root_d = {sq_root_q[WordBits-2:0], 1'b0};
    end
  end

  // three restoring divide lanes, one quotient bit a step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dtry[k] = {dr_q[k], dq_q[k][DvdBits-1]};
      if (dtry[k] >= {1'b0, len_q}) begin
        dr_d[k] = WordBits'(dtry[k] - {1'b0, len_q});
        dq_d[k] = {dq_q[k][DvdBits-2:0], 1'b1};
      end else begin
        dr_d[k] = dtry[k][WordBits-1:0];
        dq_d[k] = {dq_q[k][DvdBits-2:0], 1'b0};
      end
      dres[k] = sat_div(dneg_q[k], dq_d[k]);
    end
    nv[0] = nsel_q ? sx_q : fx_q;
    nv[1] = nsel_q ? sy_q : fy_q;
    nv[2] = nsel_q ? sz_q : fz_q;
  end

  assign pop_o    = (state_q == S_IDLE) && qstat_i.valid;
  assign done_o   = done_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      pc_q      <= '0;
      nsel_q    <= 1'b0;
      sq_cnt_q  <= '0;
      dcnt_q    <= '0;
      res_q     <= '0;
      p_q       <= '0;
      acc_q     <= '0;
      len_q     <= '0;
      sq_n_q    <= '0;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      {ex_q, ey_q, ez_q, upx_q, upy_q, upz_q} <= '0;
      {fx_q, fy_q, fz_q, sx_q, sy_q, sz_q, ux_q, uy_q, uz_q} <= '0;
      {mvx_q, mvy_q} <= '0;
      for (int k = 0; k < 3; k++) begin
        dq_q[k]   <= '0;
        dr_q[k]   <= '0;
        dneg_q[k] <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (qstat_i.valid) begin
            ex_q  <= job_i.eye_x;  ey_q  <= job_i.eye_y;  ez_q  <= job_i.eye_z;
            upx_q <= job_i.up_x;   upy_q <= job_i.up_y;   upz_q <= job_i.up_z;
            fx_q  <= job_i.fwd_x;  fy_q  <= job_i.fwd_y;  fz_q  <= job_i.fwd_z;
            pc_q    <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          p_q     <= op_a * op_b;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_d;
          case (act)
            E_NORM: begin
              nsel_q    <= (pc_q != 5'd2);
              sq_n_q    <= acc_d[2*WordBits-1:0];
              sq_rem_q  <= '0;
              sq_root_q <= '0;
              sq_cnt_q  <= 5'(WordBits - 1);
              state_q   <= S_SQRT;
            end
            E_S: begin
              case (dst)
                2'd0:    sx_q <= acc_sat;
                2'd1:    sy_q <= acc_sat;
                default: sz_q <= acc_sat;
              endcase
            end
            E_U: begin
              case (dst)
                2'd0:    ux_q <= acc_sat;
                2'd1:    uy_q <= acc_sat;
                default: uz_q <= acc_sat;
              endcase
            end
            E_MV: begin
              case (dst)
                2'd0:    mvx_q <= mv_val;
                2'd1:    mvy_q <= mv_val;
                default: ;
              endcase
            end
            default: ;
          endcase
          if (act != E_NORM) begin
            if (pc_q == LastPc) begin
              res_q.side_x   <= sx_q;  res_q.side_y <= sy_q;  res_q.side_z <= sz_q;
              res_q.cam_up_x <= ux_q;  res_q.cam_up_y <= uy_q;  res_q.cam_up_z <= uz_q;
              res_q.back_x   <= sat_neg(fx_q);
              res_q.back_y   <= sat_neg(fy_q);
              res_q.back_z   <= sat_neg(fz_q);
              res_q.move_x   <= mvx_q;
              res_q.move_y   <= mvy_q;
              res_q.move_z   <= mv_val;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              pc_q    <= pc_q + 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        S_SQRT: begin
          sq_n_q    <= {sq_n_q[2*WordBits-3:0], 2'b00};
          sq_rem_q  <= sq_rem_d;
          sq_root_q <= sq_root_d;
          sq_cnt_q  <= sq_cnt_q - 1'b1;
          if (sq_cnt_q == '0) begin
            len_q <= sq_root_d;
            if (sq_root_d > NormMinLen) begin
              for (int k = 0; k < 3; k++) begin
                dneg_q[k] <= nv[k][WordBits-1];
                dq_q[k]   <= {(nv[k][WordBits-1] ? '0 - nv[k] : nv[k]), {FracBits{1'b0}}};
                dr_q[k]   <= '0;
              end
              dcnt_q  <= 6'(DvdBits - 1);
              state_q <= S_DIV;
            end else begin
              // short vector passes through unchanged
              pc_q    <= pc_q + 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            dq_q[k] <= dq_d[k];
            dr_q[k] <= dr_d[k];
          end
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == '0) begin
            if (nsel_q) begin
              sx_q <= dres[0]; sy_q <= dres[1]; sz_q <= dres[2];
            end else begin
              fx_q <= dres[0]; fy_q <= dres[1]; fz_q <= dres[2];
            end
            pc_q    <= pc_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/look_at_view_matrix.sv =====
`default_nettype none
// Channel   Ports                      Transfer
// -------   ------------------------   ------------------------------------------
// item in   start, busy, item_i        rising edge with start high and busy low
// result    done_o, result_o           one cycle with done_o high, no back-pressure
//
// An item in the back end takes a pop from the queue, 27 shared multiply steps
// (each a multiply state and an accumulate state), two serial square roots and two
// divides of three lanes in parallel; a short vector skips its divide. The serial
// root and divide units take most of the back end's time. A two-entry job queue sits
// between front and back, so busy rises only when both entries are occupied.
// Reset clears the queue and the sequencer; no clearing pass is needed.
module look_at_view_matrix
  import lavm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire lavm_in_t  item_i,
  output logic           done_o,
  output lavm_out_t      result_o
);

  lavm_job_t   push_job, head_job;
  lavm_qstat_t qstat;
  logic        push, pop;

  // front: takes the transfer and forms target - eye
  lavm_front u_front (
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .full_i (qstat.full),
    .push_o (push),
    .job_o  (push_job)
  );

  // decouples the accept side from the long back-end sequence
  lavm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .pop_i  (pop),
    .stat_o (qstat),
    .data_o (head_job)
  );

  // back: normalize, cross products, dot products, saturation
  lavm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .job_i    (head_job),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire
